>>> hw/rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types for the trial division prime test: the control and status
// groups passed between the sequencer and the radix-2 divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

    // divider launch request from the sequencer
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // divider progress reported back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/tdpt_divider.sv
// ----------------------------------------------------------------------------
// tdpt_divider
// Radix-2 restoring divider. The dividend shifts out of the quotient
// register one bit per cycle while quotient bits shift in; one quotient
// bit is settled per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_divider #(
    parameter int WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tdpt_pkg::div_ctrl_t  ctrl,
    input  wire logic [WIDTH-1:0]     dividend,
    input  wire logic [WIDTH-1:0]     divisor,
    output tdpt_pkg::div_status_t     status,
    output logic      [WIDTH-1:0]     quotient,
    output logic      [WIDTH-1:0]     remainder
);

    localparam int CntW = $clog2(WIDTH);
    localparam logic [CntW-1:0] LastStep = CntW'(WIDTH - 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] div_reg, div_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // one restoring step: bring down the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = LastStep;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // no borrow means the divisor fits: keep the difference
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
            end
            else
            begin
                rem_next = trial[WIDTH-1:0];
            end
            quo_next = {quo_reg[WIDTH-2:0], ~diff[WIDTH]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

    // checks
    a_done_pulse : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> (busy_reg && !done_reg))
        else $error("divider did not start after launch");

    a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && div_reg != '0) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

>>> hw/rtl/trial_division_prime_test_top.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Primality test by trial division. Divisors 2, 3, 4, ... are tried in turn
// on a shared radix-2 divider until one divides exactly or exceeds the
// quotient, which is the integer form of the square root bound.
//
//   channel  signals                           width
//   in       in_valid, in_stall, candidate     NUMBER_WIDTH, signed
//   out      out_valid, out_stall, is_prime    1
//
// Each divisor passes through a launch state, the divider steps and a check
// of the quotient and remainder. A negative, zero or one candidate skips
// the divider and goes straight to the finish state.
// Reset clears the sequencer, the divider control and the output valid.
// A stalled result waits in the output register; the next item is taken
// while it waits, and its verdict holds in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test_top #(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [NUMBER_WIDTH-1:0] candidate,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                is_prime
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    localparam logic [NUMBER_WIDTH-1:0] FirstDivisor = NUMBER_WIDTH'(2);

    state_t                  state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    is_prime_reg, is_prime_next;
    logic                    verdict_reg, verdict_next;
    logic [NUMBER_WIDTH-1:0] n_reg, n_next;
    logic [NUMBER_WIDTH-1:0] d_reg, d_next;

    tdpt_pkg::div_ctrl_t     div_ctrl;
    tdpt_pkg::div_status_t   div_status;
    logic [NUMBER_WIDTH-1:0] div_quo;
    logic [NUMBER_WIDTH-1:0] div_rem;

    logic                    in_xfer;
    logic                    trivial;
    logic                    slot_free;

    // shared divider
    tdpt_divider #(
        .WIDTH (NUMBER_WIDTH)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .status    (div_status),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_stall       = (state_reg != ST_IDLE);
    assign in_xfer        = in_valid && !in_stall;
    assign div_ctrl.start = (state_reg == ST_LAUNCH);

    // negative, zero and one are never prime
    assign trivial = candidate[NUMBER_WIDTH-1] || (candidate[NUMBER_WIDTH-2:1] == '0);

    // output register can take a new result
    assign slot_free = !out_valid_reg || !out_stall;

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        verdict_next   = verdict_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        is_prime_next  = is_prime_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next = candidate;
                    d_next = FirstDivisor;
                    if (trivial)
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    // divisor beyond the quotient means it passed the square root
                    if (d_reg > div_quo)
                    begin
                        verdict_next = 1'b1;
                        state_next   = ST_FINISH;
                    end
                    else if (div_rem == '0)
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = verdict_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        is_prime_reg <= is_prime_next;
        verdict_reg  <= verdict_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    // checks
    a_done_in_divide : assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide phase");

    a_prime_positive : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && verdict_reg) |->
            (!n_reg[NUMBER_WIDTH-1] && n_reg[NUMBER_WIDTH-2:1] != '0))
        else $error("prime verdict for a value below two");

    a_divisor_floor : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAUNCH) |-> (d_reg >= FirstDivisor))
        else $error("divisor below two launched");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trial division prime test. A queue of candidates
// (directed corner values, then a random mix that keeps most searches short)
// feeds a valid/stall driver. A monitor predicts each verdict when the input
// transfer happens and checks every output transfer against the oldest one.
// Idling runs in three phases, and the receiver holds off once for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_W        = 32;
    localparam int RANDOM_ITEMS = 76;
    localparam int STUCK_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;

    typedef enum logic [1:0] {
        PH_RECV_SLOW,
        PH_SEND_SLOW,
        PH_FULL_RATE
    } idle_phase_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [NUM_W-1:0] candidate = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    is_prime;

    logic signed [NUM_W-1:0] pending_q[$];
    logic                    verdict_q[$];
    int                      total_items = 0;
    int                      sent_count = 0;
    int                      taken_count = 0;
    int                      fault_count = 0;
    int                      stuck_cycles = 0;
    int                      hold_left = 0;
    bit                      hold_done = 1'b0;
    bit                      in_taken = 1'b0;
    idle_phase_t             phase = PH_RECV_SLOW;

    trial_division_prime_test_top #(
        .NUMBER_WIDTH(NUM_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .candidate(candidate),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .is_prime (is_prime)
    );

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // primality by trial division, bound kept as d <= n / d
    function automatic logic trial_divide_prime(input logic signed [NUM_W-1:0] value);
        logic [NUM_W-1:0] n;
        logic [NUM_W-1:0] d;
        if (value <= 1)
            return 1'b0;
        n = value;
        for (d = 2; d <= n / d; d++)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_fault(input string what, input logic got, input logic want);
        $display("ERROR at %0t: %s: is_prime %b, expected %b", $time, what, got, want);
        fault_count++;
    endtask

    // sender: next candidate at the falling edge once the last transfer is done
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_q.size() > 0 &&
                $urandom_range(0, 99) >= (phase == PH_RECV_SLOW ? 15 :
                                          phase == PH_SEND_SLOW ? 52 : 0))
            begin
                candidate <= pending_q.pop_front();
                in_valid  <= 1'b1;
                sent_count++;
                if (sent_count * 3 < total_items)
                    phase = PH_RECV_SLOW;
                else if (sent_count * 3 < total_items * 2)
                    phase = PH_SEND_SLOW;
                else
                    phase = PH_FULL_RATE;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall, with one long hold-off when full rate begins
    always @(negedge clk)
    begin
        if (phase == PH_FULL_RATE && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < (phase == PH_RECV_SLOW ? 52 :
                                                   phase == PH_SEND_SLOW ? 15 : 0));
        end
    end

    // monitor: check on output transfer, predict on input transfer
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
                report_fault("result with no item outstanding", is_prime, 1'bx);
            else if (is_prime !== verdict_q[0])
                report_fault("wrong verdict", is_prime, verdict_q.pop_front());
            else
                void'(verdict_q.pop_front());
        end
        if (in_taken)
        begin
            verdict_q.insert(verdict_q.size(), trial_divide_prime(candidate));
            taken_count++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic signed [NUM_W-1:0] directed[$];
        logic        [NUM_W-1:0] raw;
        int                      kind;
        int                      fac;

        // corners: sign extremes, small values, squares of primes, long searches
        directed = '{32'sh8000_0000, -32'sd7, -32'sd2, -32'sd1, 32'sd0, 32'sd1,
                     32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd9, 32'sd25, 32'sd49,
                     32'sd97, 32'sd121, 32'sd7919, 32'sd65521, 32'sd65535,
                     32'sd994009, 32'sd1000003, 32'sh4000_0000, 32'sh3FFF_FFFF,
                     32'sh7FFF_FFFE, 32'sh7FFF_FFFD};
        foreach (directed[i])
            pending_q.insert(pending_q.size(), directed[i]);

        // random mix: mostly short searches, full-width values with small factors
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
                pending_q.insert(pending_q.size(), $urandom_range(0, 3000));
            else if (kind < 50)
                pending_q.insert(pending_q.size(), $urandom_range(3001, 200000));
            else if (kind < 55)
                pending_q.insert(pending_q.size(), -$signed($urandom_range(1, 50)));
            else if (kind < 75)
                pending_q.insert(pending_q.size(), $urandom | 32'h8000_0000);
            else
            begin
                raw = $urandom & 32'h7FFF_FFFF;
                fac = $urandom_range(2, 13);
                raw = raw - raw % fac;
                pending_q.insert(pending_q.size(), raw);
            end
        end
        total_items = pending_q.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (taken_count < total_items || verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
